/* sv/scld_pkg.sv */
// Shared types, character codes and helpers for the serial command line decoder.
// No dependencies; every other file refers to this package by scoped names.
package scld_pkg;

   localparam int LINE_LEN = 9;
   localparam int CNT_W    = $clog2(LINE_LEN + 1);
   localparam int IDX_W    = $clog2(LINE_LEN);
   localparam int WIN_LEN  = 5;

   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_DASH  = 8'd45;
   localparam logic [7:0] CH_COLON = 8'd58;
   localparam logic [7:0] CH_0     = 8'd48;
   localparam logic [7:0] CH_1     = 8'd49;
   localparam logic [7:0] CH_2     = 8'd50;
   localparam logic [7:0] CH_B     = 8'd66;
   localparam logic [7:0] CH_C     = 8'd67;
   localparam logic [7:0] CH_M     = 8'd77;

   localparam logic [31:0] TAG_MOD = "MOD:";
   localparam logic [31:0] TAG_MSK = "MSK:";
   localparam logic [31:0] TAG_ARM = "ARM:";
   localparam logic [31:0] TAG_LED = "LED:";

   // -48*111 folded modulo 256
   localparam logic [7:0] ANGLE_BIAS  = 8'd48;
   localparam logic [7:0] ANGLE_MAX   = 8'd180;
   localparam logic [7:0] ANGLE_RESET = 8'd90;
   localparam logic [7:0] MASK_RESET  = 8'd0;

   localparam int FLAG_MASK = 0;
   localparam int FLAG_ARM  = 1;
   localparam int FLAG_LED  = 2;

   typedef enum logic [1:0] {
      MODE_MANUAL = 2'd0,
      MODE_SERIAL = 2'd1,
      MODE_STORED = 2'd2
   } mode_type;

   typedef logic [WIN_LEN-1:0][7:0] window_type;

   typedef struct packed {
      logic       data_we;
      logic       eol;
      logic [7:0] rx_byte;
   } step_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       mask_open;
      logic       arm_first_pose;
      logic       led_on;
      logic [7:0] base_angle;
      logic [7:0] elbow_angle;
      logic [7:0] mask_angle;
   } result_type;

   function automatic logic match4(input window_type w, input logic [31:0] tag);
      return (w[0] == tag[31:24]) && (w[1] == tag[23:16]) &&
             (w[2] == tag[15:8]) && (w[3] == tag[7:0]);
   endfunction

endpackage

/* sv/scld_line_buf.sv */
// Line store and character count; presents the first positions of the line.
// Depends on scld_pkg.
module scld_line_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  scld_pkg::step_type    step,
   output scld_pkg::window_type  win
);

   logic [7:0]                store_ff [scld_pkg::LINE_LEN];
   logic [scld_pkg::CNT_W-1:0] count_ff;
   logic [scld_pkg::CNT_W-1:0] count_in;
   logic                       room;

   assign room = (count_ff < scld_pkg::CNT_W'(scld_pkg::LINE_LEN));

   always_comb begin
      count_in = count_ff;
      if (step.eol) begin
         count_in = '0;
      end else if (step.data_we && room) begin
         count_in = count_ff + scld_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || step.eol) begin
         for (int i = 0; i < scld_pkg::LINE_LEN; i++) begin
            store_ff[i] <= scld_pkg::CH_DASH;
         end
      end else if (step.data_we && room) begin
         store_ff[count_ff[scld_pkg::IDX_W-1:0]] <= step.rx_byte;
      end
   end

   // line end position reads as zero
   always_comb begin
      for (int p = 0; p < scld_pkg::WIN_LEN; p++) begin
         win[p] = (count_ff == scld_pkg::CNT_W'(p)) ? 8'd0 : store_ff[p];
      end
   end

endmodule

/* sv/scld_cmd_regs.sv */
// Command decode and control registers (mode, flags, servo angles).
// Depends on scld_pkg; takes the line window from scld_line_buf.
module scld_cmd_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  eol,
   input  scld_pkg::window_type  win,
   output scld_pkg::result_type  res_in
);

   scld_pkg::mode_type mode_ff, mode_in;
   logic [2:0]         flags_ff, flags_in;
   logic [7:0]         base_ff, base_in;
   logic [7:0]         elbow_ff, elbow_in;
   logic [7:0]         mask_ff, mask_in;
   logic [7:0]         raw_angle;
   logic [7:0]         angle;
   logic               active;
   logic               angle_cmd;

   assign raw_angle = win[2] * 8'd100 + win[3] * 8'd10 + win[4] + scld_pkg::ANGLE_BIAS;
   assign angle     = (raw_angle > scld_pkg::ANGLE_MAX) ? scld_pkg::ANGLE_MAX : raw_angle;
   assign angle_cmd = (win[1] == scld_pkg::CH_COLON);

   always_comb begin
      mode_in = mode_ff;
      if (scld_pkg::match4(win, scld_pkg::TAG_MOD)) begin
         unique case (win[4])
            scld_pkg::CH_0: mode_in = scld_pkg::MODE_MANUAL;
            scld_pkg::CH_1: mode_in = scld_pkg::MODE_SERIAL;
            scld_pkg::CH_2: mode_in = scld_pkg::MODE_STORED;
            default:        mode_in = mode_ff;
         endcase
      end
   end

   assign active = (mode_in == scld_pkg::MODE_SERIAL) || (mode_in == scld_pkg::MODE_STORED);

   always_comb begin
      flags_in = flags_ff;
      base_in  = base_ff;
      elbow_in = elbow_ff;
      mask_in  = mask_ff;
      if (active) begin
         priority if (scld_pkg::match4(win, scld_pkg::TAG_MSK) && win[4] == scld_pkg::CH_0) begin
            flags_in[scld_pkg::FLAG_MASK] = 1'b0;
         end else if (scld_pkg::match4(win, scld_pkg::TAG_MSK) &&
                      win[4] == scld_pkg::CH_1) begin
            flags_in[scld_pkg::FLAG_MASK] = 1'b1;
         end else if (scld_pkg::match4(win, scld_pkg::TAG_ARM) &&
                      win[4] == scld_pkg::CH_0) begin
            flags_in[scld_pkg::FLAG_ARM] = 1'b0;
         end else if (scld_pkg::match4(win, scld_pkg::TAG_ARM) &&
                      win[4] == scld_pkg::CH_1) begin
            flags_in[scld_pkg::FLAG_ARM] = 1'b1;
         end else if (scld_pkg::match4(win, scld_pkg::TAG_LED) &&
                      win[4] == scld_pkg::CH_0) begin
            flags_in[scld_pkg::FLAG_LED] = 1'b0;
         end else if (scld_pkg::match4(win, scld_pkg::TAG_LED) &&
                      win[4] == scld_pkg::CH_1) begin
            flags_in[scld_pkg::FLAG_LED] = 1'b1;
         end else begin
            flags_in = flags_ff;
         end
         if (angle_cmd && win[0] == scld_pkg::CH_B) begin
            base_in = angle;
         end
         if (angle_cmd && win[0] == scld_pkg::CH_C) begin
            elbow_in = angle;
         end
         if (angle_cmd && win[0] == scld_pkg::CH_M) begin
            mask_in = angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= scld_pkg::MODE_MANUAL;
         flags_ff <= '0;
         base_ff  <= scld_pkg::ANGLE_RESET;
         elbow_ff <= scld_pkg::ANGLE_RESET;
         mask_ff  <= scld_pkg::MASK_RESET;
      end else if (eol) begin
         mode_ff  <= mode_in;
         flags_ff <= flags_in;
         base_ff  <= base_in;
         elbow_ff <= elbow_in;
         mask_ff  <= mask_in;
      end
   end

   always_comb begin
      res_in.mode           = mode_in;
      res_in.mask_open      = flags_in[scld_pkg::FLAG_MASK];
      res_in.arm_first_pose = flags_in[scld_pkg::FLAG_ARM];
      res_in.led_on         = flags_in[scld_pkg::FLAG_LED];
      res_in.base_angle     = base_in;
      res_in.elbow_angle    = elbow_in;
      res_in.mask_angle     = mask_in;
   end

endmodule

/* sv/serial_command_line_decoder_unit.sv */
// Top level of the serial command line decoder: input register, line store,
// command decode and result register. Depends on scld_pkg, scld_line_buf, scld_cmd_regs.
//
// Usage:
//   req_* carries one received byte per item. Bytes other than 10 and 13 are
//   collected into the line (extra bytes past the line length are dropped);
//   10 or 13 ends the line and produces exactly one rsp_* item holding mode,
//   the three flags and the three servo angles after the decode.
//   A line end byte passes the input register and then the result register before
//   it shows as rsp_valid. Throughput: one byte per cycle while req_stall is low,
//   set by the single decode step between the input register and the result register.
//   rsp_stall holds the result register; data bytes keep flowing while it
//   is held, and req_stall rises only when a line end reaches the decode
//   step with the previous result still untaken.
//   Reset fills the line with '-', clears the count, sets mode 0, flags 0,
//   base and elbow to 90 and mask angle to 0, and empties both stages.
module serial_command_line_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_mode,
   output logic       rsp_mask_open,
   output logic       rsp_arm_first_pose,
   output logic       rsp_led_on,
   output logic [7:0] rsp_base_angle,
   output logic [7:0] rsp_elbow_angle,
   output logic [7:0] rsp_mask_angle
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_eol;
   logic                 proc_go;
   logic                 rsp_valid_ff;
   scld_pkg::result_type rsp_ff;
   scld_pkg::result_type res_in;
   scld_pkg::step_type   step;
   scld_pkg::window_type win;

   assign in_eol  = (in_byte_ff == scld_pkg::CH_LF) || (in_byte_ff == scld_pkg::CH_CR);
   assign proc_go = in_valid_ff && (!in_eol || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !proc_go;

   assign step.data_we = proc_go && !in_eol;
   assign step.eol     = proc_go && in_eol;
   assign step.rx_byte = in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   scld_line_buf u_line_buf (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .win   (win)
   );

   scld_cmd_regs u_cmd_regs (
      .clock  (clock),
      .reset  (reset),
      .eol    (step.eol),
      .win    (win),
      .res_in (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step.eol) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step.eol) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = rsp_ff.mode;
   assign rsp_mask_open      = rsp_ff.mask_open;
   assign rsp_arm_first_pose = rsp_ff.arm_first_pose;
   assign rsp_led_on         = rsp_ff.led_on;
   assign rsp_base_angle     = rsp_ff.base_angle;
   assign rsp_elbow_angle    = rsp_ff.elbow_angle;
   assign rsp_mask_angle     = rsp_ff.mask_angle;

endmodule
